FILE: design/vrba_pkg.sv
// Shared types and constants for the video RAM bus access unit.
`timescale 1ns / 1ps
package vrba_pkg;

  localparam int VRAM_BYTES  = 98304;
  localparam int LANES       = 4;
  localparam int LANE_DEPTH  = VRAM_BYTES / LANES;
  localparam int LANE_AW     = $clog2(LANE_DEPTH);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [16:0] MIRROR_HIGH_MASK = 17'h17fff;
  localparam logic [16:0] MIRROR_LOW_MASK  = 17'h0ffff;
  localparam logic [16:0] OBJ_BASE_TEXT    = 17'h10000;
  localparam logic [16:0] OBJ_BASE_BITMAP  = 17'h14000;

  localparam logic       CMD_READ  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_WORD,
    SEL_HALF_LO,
    SEL_HALF_HI,
    SEL_BYTE0,
    SEL_BYTE1,
    SEL_BYTE2,
    SEL_BYTE3
  } res_sel_t;

  typedef struct packed {
    logic [LANES-1:0]   lane_we;
    logic               rd;
    logic [LANE_AW-1:0] word_addr;
    logic [31:0]        wdata;
    res_sel_t           sel;
  } queue_entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

endpackage

FILE: design/video_ram_bus_access_unit.sv
// Top level of the video RAM bus access unit.
`timescale 1ns / 1ps
// 96 KiB byte-addressed video memory with one stream port for accesses and one for
// results. Every transaction returns exactly one result (zero for writes). The front
// end takes a transaction per cycle while its queue has room; the back end issues one
// access to the four byte-lane RAMs, and the result passes through the registered RAM
// read and the single result register; no access issues while RAM data is pending or
// a result waits unaccepted. The memory is not cleared: read only what has been
// written. Write bg_mode via cfg_wen/cfg_wdata only while idle (not enforced here).
module video_ram_bus_access_unit #(
  parameter int QUEUE_DEPTH = vrba_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_wdata,   // bg_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,     // offset[16:0], write_data[48:17], zero pad
  input  logic [2:0]  s_tuser,     // cmd[0], access_size[2:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata      // read_data[31:0]
);

  vrba_pkg::queue_status_t q_status;
  vrba_pkg::queue_entry_t  push_entry;
  vrba_pkg::queue_entry_t  head;
  logic                    push;
  logic                    pop;

  vrba_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_entry(push_entry)
  );

  vrba_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  vrba_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_status(q_status),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

FILE: design/vrba_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module vrba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: design/vrba_front.sv
// Front end: accepts transactions, mirrors and aligns the offset, builds lane commands.
`timescale 1ns / 1ps
module vrba_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [2:0]             cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [55:0]            s_tdata,
  input  logic [2:0]             s_tuser,
  input  vrba_pkg::queue_status_t q_status,
  output logic                   push,
  output vrba_pkg::queue_entry_t push_entry
);

  logic [2:0]  bg_mode;
  logic        cmd;
  logic [1:0]  access_size;
  logic [16:0] offset;
  logic [31:0] write_data;
  logic [16:0] addr;
  logic        dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_mode <= 3'd0;
    end else if (cfg_wen) begin
      bg_mode <= cfg_wdata;
    end
  end

  assign cmd         = s_tuser[0];
  assign access_size = s_tuser[2:1];
  assign offset      = s_tdata[16:0];
  assign write_data  = s_tdata[48:17];

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  assign addr = offset[16] ? (offset & vrba_pkg::MIRROR_HIGH_MASK)
                           : (offset & vrba_pkg::MIRROR_LOW_MASK);

  // object region rejects byte writes: from 0x10000 in bg_mode 0-2, from 0x14000 in 3-5
  always_comb begin
    dropped = 1'b0;
    if ((bg_mode inside {[3'd0:3'd2]}) && addr >= vrba_pkg::OBJ_BASE_TEXT) begin
      dropped = 1'b1;
    end
    if ((bg_mode inside {[3'd0:3'd5]}) && addr >= vrba_pkg::OBJ_BASE_BITMAP) begin
      dropped = 1'b1;
    end
  end

  always_comb begin
    push_entry.word_addr = addr[16:2];
    push_entry.lane_we   = '0;
    push_entry.rd        = 1'b0;
    push_entry.wdata     = write_data;
    push_entry.sel       = vrba_pkg::SEL_ZERO;
    if (cmd == vrba_pkg::CMD_READ) begin
      case (access_size)
        vrba_pkg::SIZE_WORD: begin
          push_entry.rd  = 1'b1;
          push_entry.sel = vrba_pkg::SEL_WORD;
        end
        vrba_pkg::SIZE_HALF: begin
          push_entry.rd  = 1'b1;
          push_entry.sel = addr[1] ? vrba_pkg::SEL_HALF_HI : vrba_pkg::SEL_HALF_LO;
        end
        vrba_pkg::SIZE_BYTE: begin
          push_entry.rd = 1'b1;
          case (addr[1:0])
            2'd0:    push_entry.sel = vrba_pkg::SEL_BYTE0;
            2'd1:    push_entry.sel = vrba_pkg::SEL_BYTE1;
            2'd2:    push_entry.sel = vrba_pkg::SEL_BYTE2;
            default: push_entry.sel = vrba_pkg::SEL_BYTE3;
          endcase
        end
        default: ;
      endcase
    end else begin
      case (access_size)
        vrba_pkg::SIZE_WORD: begin
          push_entry.lane_we = 4'b1111;
        end
        vrba_pkg::SIZE_HALF: begin
          push_entry.lane_we = addr[1] ? 4'b1100 : 4'b0011;
          push_entry.wdata   = {write_data[15:0], write_data[15:0]};
        end
        vrba_pkg::SIZE_BYTE: begin
          // byte is stored to both bytes of its halfword
          push_entry.lane_we = dropped ? 4'b0000 : (addr[1] ? 4'b1100 : 4'b0011);
          push_entry.wdata   = {4{write_data[7:0]}};
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/vrba_queue.sv
// Short FIFO of lane commands between front and back ends.
`timescale 1ns / 1ps
module vrba_queue #(
  parameter int DEPTH = vrba_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  vrba_pkg::queue_entry_t  push_entry,
  input  logic                    pop,
  output vrba_pkg::queue_entry_t  head,
  output vrba_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vrba_pkg::queue_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign head             = entries[rptr];
  assign status.not_empty = (count != '0);
  assign status.full      = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/vrba_back.sv
// Back end: drives the four byte-lane RAMs and forms the result.
`timescale 1ns / 1ps
module vrba_back (
  input  logic                    clk,
  input  logic                    rst,
  input  vrba_pkg::queue_entry_t  head,
  input  vrba_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [31:0]             m_tdata
);

  logic                            pending;
  vrba_pkg::res_sel_t              sel;
  logic [vrba_pkg::LANES*8-1:0]    lane_rdata;
  logic [31:0]                     result;

  assign pop = q_status.not_empty && !pending && (!m_tvalid || m_tready);

  for (genvar i = 0; i < vrba_pkg::LANES; i++) begin : g_lane
    vrba_ram #(
      .WIDTH(8),
      .DEPTH(vrba_pkg::LANE_DEPTH)
    ) u_ram (
      .clk  (clk),
      .en   (pop && (head.rd || head.lane_we[i])),
      .we   (head.lane_we[i]),
      .addr (head.word_addr),
      .wdata(head.wdata[i*8 +: 8]),
      .rdata(lane_rdata[i*8 +: 8])
    );
  end

  always_comb begin
    case (sel)
      vrba_pkg::SEL_WORD:    result = lane_rdata;
      vrba_pkg::SEL_HALF_LO: result = {16'd0, lane_rdata[15:0]};
      vrba_pkg::SEL_HALF_HI: result = {16'd0, lane_rdata[31:16]};
      vrba_pkg::SEL_BYTE0:   result = {24'd0, lane_rdata[7:0]};
      vrba_pkg::SEL_BYTE1:   result = {24'd0, lane_rdata[15:8]};
      vrba_pkg::SEL_BYTE2:   result = {24'd0, lane_rdata[23:16]};
      vrba_pkg::SEL_BYTE3:   result = {24'd0, lane_rdata[31:24]};
      default:               result = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sel <= head.sel;
    end
    if (pending) begin
      m_tdata <= result;
    end
  end

  // result slot is always free when the RAM data lands
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      pending <= pop;
      if (pending) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the video RAM bus access unit.
`timescale 1ns / 1ps
module tb;
  import vrba_pkg::*;

  localparam logic [1:0] SIZE_NONE = 2'd3;
  localparam int N_DIRECTED = 24;
  localparam int PHASE_ITEMS = 130;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  size;
    logic [16:0] off;
    logic [31:0] wdata;
    logic        typed;
    logic [31:0] rdata;
  } access_row_t;

  localparam access_row_t DIRECTED [N_DIRECTED] = '{
    '{CMD_WRITE, SIZE_WORD, 17'h00000, 32'hdeadbeef, 1'b1, 32'h00000000},
    '{CMD_READ,  SIZE_WORD, 17'h00000, 32'h00000000, 1'b1, 32'hdeadbeef},
    '{CMD_READ,  SIZE_WORD, 17'h00003, 32'h00000000, 1'b1, 32'hdeadbeef},
    '{CMD_READ,  SIZE_HALF, 17'h00003, 32'h00000000, 1'b1, 32'h0000dead},
    '{CMD_READ,  SIZE_BYTE, 17'h00001, 32'h00000000, 1'b1, 32'h000000be},
    '{CMD_WRITE, SIZE_HALF, 17'h1ffff, 32'h0000a55a, 1'b1, 32'h00000000},
    '{CMD_READ,  SIZE_HALF, 17'h17ffe, 32'h00000000, 1'b1, 32'h0000a55a},
    '{CMD_READ,  SIZE_BYTE, 17'h1ffff, 32'h00000000, 1'b1, 32'h000000a5},
    '{CMD_WRITE, SIZE_WORD, 17'h10000, 32'h11223344, 1'b1, 32'h00000000},
    '{CMD_WRITE, SIZE_BYTE, 17'h10001, 32'h000000ff, 1'b1, 32'h00000000},
    '{CMD_READ,  SIZE_WORD, 17'h10000, 32'h00000000, 1'b1, 32'h11223344},
    '{CMD_WRITE, SIZE_BYTE, 17'h0ffff, 32'h0000007e, 1'b1, 32'h00000000},
    '{CMD_READ,  SIZE_HALF, 17'h0fffe, 32'h00000000, 1'b1, 32'h00007e7e},
    '{CMD_READ,  SIZE_NONE, 17'h00000, 32'h00000000, 1'b1, 32'h00000000},
    '{CMD_WRITE, SIZE_NONE, 17'h00000, 32'hffffffff, 1'b1, 32'h00000000},
    '{CMD_READ,  SIZE_WORD, 17'h00000, 32'h00000000, 1'b1, 32'hdeadbeef},
    '{CMD_WRITE, SIZE_WORD, 17'h1fffc, 32'hffffffff, 1'b1, 32'h00000000},
    '{CMD_READ,  SIZE_WORD, 17'h17ffc, 32'h00000000, 1'b1, 32'hffffffff},
    '{CMD_WRITE, SIZE_WORD, 17'h18000, 32'hcafef00d, 1'b1, 32'h00000000},
    '{CMD_READ,  SIZE_WORD, 17'h10000, 32'h00000000, 1'b1, 32'hcafef00d},
    '{CMD_WRITE, SIZE_WORD, 17'h08000, 32'h00000000, 1'b1, 32'h00000000},
    '{CMD_READ,  SIZE_BYTE, 17'h08003, 32'h00000000, 1'b1, 32'h00000000},
    '{CMD_WRITE, SIZE_BYTE, 17'h04005, 32'h12345699, 1'b1, 32'h00000000},
    '{CMD_READ,  SIZE_HALF, 17'h04004, 32'h00000000, 1'b1, 32'h00009999}
  };

  localparam logic [16:0] WINDOWS [6] = '{
    17'h00000, 17'h07fe0, 17'h0abc0, 17'h0ffe0, 17'h13fe0, 17'h17fc0
  };

  localparam logic [2:0] MODE_SEQ [8] = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd6, 3'd1, 3'd4};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  logic [7:0]  vram_image [VRAM_BYTES];
  bit          vram_known [VRAM_BYTES];
  logic [2:0]  bg_mode_now = 3'd0;
  logic [31:0] rdata_pending [$];
  logic [31:0] rdata_want;
  int          mismatches = 0;
  bit          no_idle = 1'b0;

  video_ram_bus_access_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [16:0] mirror(input logic [16:0] raw);
    return raw[16] ? (raw & MIRROR_HIGH_MASK) : (raw & MIRROR_LOW_MASK);
  endfunction

  function automatic bit read_is_defined(input logic [1:0] size, input logic [16:0] raw);
    logic [16:0] a;
    int n;
    a = mirror(raw);
    case (size)
      SIZE_WORD: begin a[1:0] = 2'b00; n = 4; end
      SIZE_HALF: begin a[0] = 1'b0; n = 2; end
      SIZE_BYTE: n = 1;
      default:   n = 0;
    endcase
    for (int i = 0; i < n; i++)
      if (!vram_known[a + i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void vram_put(input logic [16:0] a, input logic [7:0] v);
    vram_image[a] = v;
    vram_known[a] = 1'b1;
  endfunction

  // Applies one transaction to the memory image and returns its result.
  function automatic logic [31:0] vram_access(input logic cmd, input logic [1:0] size,
                                              input logic [16:0] raw,
                                              input logic [31:0] wdata);
    logic [16:0] a;
    logic [31:0] r;
    bit dropped;
    a = mirror(raw);
    r = '0;
    if (cmd == CMD_READ) begin
      case (size)
        SIZE_WORD: begin
          a[1:0] = 2'b00;
          r = {vram_image[a + 3], vram_image[a + 2], vram_image[a + 1], vram_image[a]};
        end
        SIZE_HALF: begin
          a[0] = 1'b0;
          r = {16'h0, vram_image[a + 1], vram_image[a]};
        end
        SIZE_BYTE: r = {24'h0, vram_image[a]};
        default: r = '0;
      endcase
    end else begin
      case (size)
        SIZE_WORD: begin
          a[1:0] = 2'b00;
          for (int i = 0; i < 4; i++) vram_put(17'(a + i), wdata[8*i +: 8]);
        end
        SIZE_HALF: begin
          a[0] = 1'b0;
          vram_put(a, wdata[7:0]);
          vram_put(17'(a + 17'd1), wdata[15:8]);
        end
        SIZE_BYTE: begin
          dropped = (bg_mode_now <= 3'd2 && a >= OBJ_BASE_TEXT) ||
                    (bg_mode_now <= 3'd5 && a >= OBJ_BASE_BITMAP);
          if (!dropped) begin
            a[0] = 1'b0;
            vram_put(a, wdata[7:0]);
            vram_put(17'(a + 17'd1), wdata[7:0]);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic logic [16:0] pick_offset();
    logic [16:0] m;
    if ($urandom_range(0, 9) == 0) return 17'($urandom);
    m = WINDOWS[$urandom_range(0, 5)] + 17'($urandom_range(0, 63));
    if (m[16] && $urandom_range(0, 1)) m[15] = 1'b1;
    return m;
  endfunction

  task automatic send_access(input logic cmd, input logic [1:0] size,
                             input logic [16:0] off, input logic [31:0] wdata,
                             input bit typed, input logic [31:0] typed_rdata);
    logic [31:0] predicted;
    while (!no_idle && $urandom_range(0, 99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, wdata, off};
    s_tuser  <= {size, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = vram_access(cmd, size, off, wdata);
    rdata_pending.push_back(typed ? typed_rdata : predicted);
  endtask

  task automatic set_bg_mode(input logic [2:0] mode);
    s_tvalid <= 1'b0;
    while (rdata_pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_wen <= 1'b0;
    bg_mode_now = mode;
  endtask

  task automatic send_random();
    logic        cmd;
    logic [1:0]  size;
    logic [16:0] off;
    int          r;
    r = $urandom_range(0, 19);
    size = (r == 0) ? SIZE_NONE : 2'(r % 3);
    cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
    off = pick_offset();
    if (cmd == CMD_READ) begin
      for (int t = 0; t < 8 && !read_is_defined(size, off); t++) off = pick_offset();
      if (!read_is_defined(size, off)) cmd = CMD_WRITE;
    end
    send_access(cmd, size, off, $urandom, 1'b0, '0);
  endtask

  task automatic note_mismatch(input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("read_data mismatch at %0t: expected %08h, got %08h", $realtime, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (rdata_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %08h at %0t", m_tdata, $realtime);
      end else begin
        rdata_want = rdata_pending.pop_front();
        if (m_tdata !== rdata_want) note_mismatch(rdata_want, m_tdata);
      end
    end
    m_tready <= !rst && (no_idle || $urandom_range(0, 99) >= 23);
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_bg_mode(MODE_SEQ[0]);
    foreach (DIRECTED[i])
      send_access(DIRECTED[i].cmd, DIRECTED[i].size, DIRECTED[i].off, DIRECTED[i].wdata,
                  DIRECTED[i].typed, DIRECTED[i].rdata);
    for (int p = 0; p < 8; p++) begin
      if (p != 0) set_bg_mode(MODE_SEQ[p]);
      no_idle = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;
    while (rdata_pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && rdata_pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
